FILE: hdl/dht_pkg.sv
package dht_pkg;

	localparam int KEY_W = 31;
	localparam int SLOT_OUT_W = 4;

	localparam int DEF_TABLE_SLOTS = 16;
	localparam int DEF_STEP_MODULUS = 6;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_SEARCH = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]       mode;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [SLOT_OUT_W-1:0] slot;
	} rsp_t;

endpackage

FILE: hdl/double_hash_table.sv
// channel   direction  handshake                      word
// cmd       in         start high while busy low      dht_pkg::req_t {mode, key}
// rsp       out        done high for one cycle        dht_pkg::rsp_t {status, slot}
//
// after reset the block clears the table, one slot a cycle, with busy high.
// an operation first takes key mod TABLE_SLOTS, then key mod STEP_MODULUS, and then folds
// the step into the table, all in one shared multiply unit,
// then probes (registered table read, then compare), up to TABLE_SLOTS probes;
// the next start is taken the cycle done is high.
// key zero or unused mode answers the cycle after start. the result strobe cannot be held off.
module double_hash_table #(
	parameter int TABLE_SLOTS  = dht_pkg::DEF_TABLE_SLOTS,
	parameter int STEP_MODULUS = dht_pkg::DEF_STEP_MODULUS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  dht_pkg::req_t cmd,
	output logic          done,
	output dht_pkg::rsp_t rsp
);

	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int MW_A   = $clog2(TABLE_SLOTS + 1);
	localparam int MW_B   = $clog2(STEP_MODULUS + 1);
	localparam int MW     = (MW_A > MW_B) ? MW_A : MW_B;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HOME  = 3'd2;
	localparam logic [2:0] S_STEP  = 3'd3;
	localparam logic [2:0] S_STEPN = 3'd4;
	localparam logic [2:0] S_READ  = 3'd5;
	localparam logic [2:0] S_CHECK = 3'd6;

	logic [2:0] state_q;

	logic [1:0]                mode_q;
	logic [dht_pkg::KEY_W-1:0] key_q;
	logic [SLOT_W-1:0]         home_q;
	logic [SLOT_W-1:0]         step_q;
	logic [SLOT_W-1:0]         pos_q;
	logic [SLOT_W-1:0]         probe_q;
	logic                      done_q;
	dht_pkg::rsp_t             rsp_q;

	logic [dht_pkg::KEY_W-1:0] mem [TABLE_SLOTS];
	logic [dht_pkg::KEY_W-1:0] rd_data_q;

	logic                      rem_go;
	logic [dht_pkg::KEY_W-1:0] rem_num;
	logic                      rem_sel;
	logic                      rem_done;
	logic [MW-1:0]             rem;
	logic [MW-1:0]             stp;

	logic                      bad_cmd;
	logic                      empty;
	logic                      hit;
	logic                      stop;
	logic                      last_probe;
	logic [SLOT_W:0]           pos_sum;
	logic [SLOT_W-1:0]         pos_next;

	logic                      wr_en;
	logic [SLOT_W-1:0]         wr_addr;
	logic [dht_pkg::KEY_W-1:0] wr_data;

	dht_rem #(
		.MW    (MW),
		.MOD_A (TABLE_SLOTS),
		.MOD_B (STEP_MODULUS)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (rem_go),
		.num     (rem_num),
		.sel     (rem_sel),
		.done    (rem_done),
		.rem     (rem)
	);

	assign bad_cmd = (cmd.key == '0) || (cmd.mode != dht_pkg::MODE_INSERT &&
		cmd.mode != dht_pkg::MODE_SEARCH && cmd.mode != dht_pkg::MODE_DELETE);

	// a zero step probes with step one
	assign stp = (rem == '0) ? MW'(1) : rem;

	always_comb begin
		rem_go  = 1'b0;
		rem_num = key_q;
		rem_sel = 1'b0;
		if (state_q == S_IDLE && start && !bad_cmd) begin
			rem_go  = 1'b1;
			rem_num = cmd.key;
		end else if (state_q == S_HOME && rem_done) begin
			rem_go  = 1'b1;
			rem_sel = 1'b1;
		end else if (state_q == S_STEP && rem_done) begin
			// step goes through again to fold it below the table size
			rem_go  = 1'b1;
			rem_num = dht_pkg::KEY_W'(stp);
		end
	end

	assign empty      = (rd_data_q == '0);
	assign hit        = (rd_data_q == key_q);
	assign stop       = (mode_q == dht_pkg::MODE_INSERT) ? empty : (hit || empty);
	assign last_probe = (probe_q == SLOT_W'(TABLE_SLOTS - 1));
	assign pos_sum    = {1'b0, pos_q} + {1'b0, step_q};
	assign pos_next   = (pos_sum >= (SLOT_W + 1)'(TABLE_SLOTS)) ?
		SLOT_W'(pos_sum - (SLOT_W + 1)'(TABLE_SLOTS)) : pos_sum[SLOT_W-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = '0;
		if (state_q == S_CLEAR) begin
			wr_en = 1'b1;
		end else if (state_q == S_CHECK) begin
			if (mode_q == dht_pkg::MODE_INSERT && empty) begin
				wr_en   = 1'b1;
				wr_data = key_q;
			end else if (mode_q == dht_pkg::MODE_DELETE && hit) begin
				wr_en = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			pos_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (pos_q == SLOT_W'(TABLE_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
					pos_q <= pos_q + SLOT_W'(1);
				end
				S_IDLE: begin
					if (start) begin
						if (bad_cmd) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_HOME;
						end
					end
				end
				S_HOME: begin
					if (rem_done) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (rem_done) begin
						state_q <= S_STEPN;
					end
				end
				S_STEPN: begin
					if (rem_done) begin
						pos_q   <= home_q;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (stop || last_probe) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						pos_q   <= pos_next;
						state_q <= S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mode_q       <= cmd.mode;
			key_q        <= cmd.key;
			rsp_q.status <= dht_pkg::ST_MISS;
			rsp_q.slot   <= '0;
		end
		if (state_q == S_HOME && rem_done) begin
			home_q <= rem[SLOT_W-1:0];
		end
		if (state_q == S_STEPN && rem_done) begin
			step_q  <= rem[SLOT_W-1:0];
			probe_q <= '0;
		end
		if (state_q == S_CHECK) begin
			probe_q <= probe_q + SLOT_W'(1);
			if (stop) begin
				if (hit || (mode_q == dht_pkg::MODE_INSERT && empty)) begin
					rsp_q.status <= dht_pkg::ST_OK;
					rsp_q.slot   <= dht_pkg::SLOT_OUT_W'(pos_q);
				end else begin
					rsp_q.status <= dht_pkg::ST_MISS;
					rsp_q.slot   <= '0;
				end
			end else if (last_probe) begin
				rsp_q.status <= (mode_q == dht_pkg::MODE_INSERT) ?
					dht_pkg::ST_FULL : dht_pkg::ST_MISS;
				rsp_q.slot   <= '0;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_rem_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> (state_q == S_HOME || state_q == S_STEP || state_q == S_STEPN))
		else $error("remainder finished outside a division state");

	a_write_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && wr_en) |->
		((mode_q == dht_pkg::MODE_INSERT && empty) || (mode_q == dht_pkg::MODE_DELETE && hit)))
		else $error("table written without an empty slot on insert or a hit on delete");

	a_read_check: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> state_q == S_CHECK)
		else $error("probe read not followed by its compare");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != dht_pkg::ST_OK) |-> rsp.slot == '0)
		else $error("slot nonzero on a failed operation");

endmodule

FILE: hdl/dht_rem.sv
// remainder by one of two fixed moduli (up to 4096) by reciprocal multiplication
// fold: x = hi * (2^16 mod m) + lo, below 2^28; then q = x * r >> s; then rem = x - q * m
// one multiplier serves all three steps, run in turn as phases fold, recip and back; rem is ready with done after back
module dht_rem #(
	parameter int MW    = 13,
	parameter int MOD_A = dht_pkg::DEF_TABLE_SLOTS,
	parameter int MOD_B = dht_pkg::DEF_STEP_MODULUS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [dht_pkg::KEY_W-1:0]  num,
	input  logic                       sel,
	output logic                       done,
	output logic [MW-1:0]              rem
);

	localparam int LO_W = 16;
	localparam int XW   = 28;
	localparam int QW   = XW - 1;
	localparam int BW   = 30;
	localparam int PW   = XW + BW;

	// exact for every x below 2^XW with s = XW + ceil(log2 m) and r = ceil(2^s / m)
	localparam int     S_A = XW + $clog2(MOD_A);
	localparam int     S_B = XW + $clog2(MOD_B);
	localparam longint R_A = ((longint'(1) << S_A) + longint'(MOD_A) - 1) / longint'(MOD_A);
	localparam longint R_B = ((longint'(1) << S_B) + longint'(MOD_B) - 1) / longint'(MOD_B);
	localparam longint C_A = (longint'(1) << LO_W) % longint'(MOD_A);
	localparam longint C_B = (longint'(1) << LO_W) % longint'(MOD_B);

	localparam logic [1:0] P_FOLD  = 2'd0;
	localparam logic [1:0] P_RECIP = 2'd1;
	localparam logic [1:0] P_BACK  = 2'd2;

	logic                      run_q;
	logic                      done_q;
	logic [1:0]                phase_q;
	logic                      sel_q;
	logic [dht_pkg::KEY_W-1:0] num_q;
	logic [XW-1:0]             x_q;
	logic [QW-1:0]             q_q;
	logic [MW-1:0]             rem_q;

	logic [XW-1:0] op_a;
	logic [BW-1:0] op_b;
	logic [PW-1:0] prod;
	logic [QW-1:0] shr_a;
	logic [QW-1:0] shr_b;
	logic [XW-1:0] x_next;
	logic [XW-1:0] back;

	always_comb begin
		op_a = XW'(num_q[dht_pkg::KEY_W-1:LO_W]);
		op_b = sel_q ? BW'(C_B) : BW'(C_A);
		if (phase_q == P_RECIP) begin
			op_a = x_q;
			op_b = sel_q ? BW'(R_B) : BW'(R_A);
		end else if (phase_q == P_BACK) begin
			op_a = XW'(q_q);
			op_b = sel_q ? BW'(MOD_B) : BW'(MOD_A);
		end
	end

	assign prod   = PW'(op_a) * PW'(op_b);
	assign shr_a  = QW'(prod >> S_A);
	assign shr_b  = QW'(prod >> S_B);
	assign x_next = prod[XW-1:0] + XW'(num_q[LO_W-1:0]);
	assign back   = x_q - prod[XW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= P_FOLD;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q   <= 1'b1;
				phase_q <= P_FOLD;
			end else if (run_q) begin
				if (phase_q == P_BACK) begin
					run_q   <= 1'b0;
					done_q  <= 1'b1;
					phase_q <= P_FOLD;
				end else begin
					phase_q <= phase_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			sel_q <= sel;
		end else if (run_q) begin
			if (phase_q == P_FOLD) begin
				x_q <= x_next;
			end
			if (phase_q == P_RECIP) begin
				q_q <= sel_q ? shr_b : shr_a;
			end
			if (phase_q == P_BACK) begin
				rem_q <= back[MW-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> !run_q)
		else $error("remainder started while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("remainder done held over two cycles");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rem < (sel_q ? MW'(MOD_B) : MW'(MOD_A))))
		else $error("remainder not below its modulus");

endmodule

FILE: sim/tb_double_hash_table.sv
`timescale 1ns / 1ps

module tb_double_hash_table;

	localparam int KEY_W = dht_pkg::KEY_W;
	localparam int SLOT_OUT_W = dht_pkg::SLOT_OUT_W;
	localparam int SLOTS = dht_pkg::DEF_TABLE_SLOTS;
	localparam int STRIDE_MOD = dht_pkg::DEF_STEP_MODULUS;
	localparam int N_ITEMS = 1600;
	localparam int TAIL_CYCLES = 120;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

	// keeps its own copy of the table and a queue of the answers still owed
	class dht_scoreboard_t;
		logic [KEY_W-1:0] stored [SLOTS];
		dht_pkg::rsp_t owed [$];
		int errors;

		function new();
			foreach (stored[i]) stored[i] = '0;
			errors = 0;
		endfunction

		function int probe_slot(logic [KEY_W-1:0] key, int i);
			longint k;
			longint stride;
			k = key;
			stride = k % STRIDE_MOD;
			if (stride == 0) stride = 1;
			return int'(((k % SLOTS) + longint'(i) * stride) % SLOTS);
		endfunction

		function void note_cmd(dht_pkg::req_t r);
			dht_pkg::rsp_t want;
			int s;
			want.status = dht_pkg::ST_MISS;
			want.slot = '0;
			if (r.key != '0) begin
				if (r.mode == dht_pkg::MODE_INSERT) begin
					want.status = dht_pkg::ST_FULL;
					for (int i = 0; i < SLOTS; i++) begin
						s = probe_slot(r.key, i);
						if (stored[s] == '0) begin
							stored[s] = r.key;
							want.status = dht_pkg::ST_OK;
							want.slot = s[SLOT_OUT_W-1:0];
							break;
						end
					end
				end else if (r.mode == dht_pkg::MODE_SEARCH ||
					r.mode == dht_pkg::MODE_DELETE) begin
					for (int i = 0; i < SLOTS; i++) begin
						s = probe_slot(r.key, i);
						if (stored[s] == r.key) begin
							// no tombstone: the slot just becomes empty
							if (r.mode == dht_pkg::MODE_DELETE) stored[s] = '0;
							want.status = dht_pkg::ST_OK;
							want.slot = s[SLOT_OUT_W-1:0];
							break;
						end
						if (stored[s] == '0) break;
					end
				end
			end
			owed.push_back(want);
		endfunction

		task report(string what);
			$display("[%0t] ERROR %s", $realtime, what);
			errors++;
		endtask

		task check_rsp(dht_pkg::rsp_t got);
			dht_pkg::rsp_t want;
			if (owed.size() == 0) begin
				report($sformatf("unexpected word status=%0d slot=%0d", got.status, got.slot));
				return;
			end
			want = owed.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, wanted %0d", got.status, want.status));
			if (got.slot !== want.slot)
				report($sformatf("slot %0d, wanted %0d", got.slot, want.slot));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	dht_pkg::req_t cmd = '0;
	logic done;
	dht_pkg::rsp_t rsp;

	dht_scoreboard_t sb = new();
	int sent = 0;
	int cycles = 0;

	double_hash_table #(
		.TABLE_SLOTS(SLOTS),
		.STEP_MODULUS(STRIDE_MOD)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.rsp(rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_rsp(rsp);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("double_hash_table: mismatch");
			$finish;
		end
	end

	// start stays high between back-to-back words, so it is lowered only before a gap or a drain
	task automatic send_cmd(input logic [1:0] mode, input logic [KEY_W-1:0] key);
		int gap;
		dht_pkg::req_t r;
		gap = $urandom_range(0, 5);
		r.mode = mode;
		r.key = key;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= r;
		do @(posedge clk); while (busy);
		sb.note_cmd(r);
		sent++;
	endtask

	task automatic drain_owed();
		start <= 1'b0;
		do @(negedge clk); while (sb.owed.size() != 0);
		@(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		int roll;
		logic [KEY_W-1:0] held;
		roll = $urandom_range(0, 99);
		held = sb.stored[$urandom_range(0, SLOTS - 1)];
		if (roll < 50 && held != '0) return held;
		if (roll < 80) return KEY_W'($urandom_range(1, 40));
		if (roll < 98) return KEY_W'($urandom());
		return '0;
	endfunction

	function automatic logic [1:0] pick_mode(phase_t kind);
		int roll;
		roll = $urandom_range(0, 99);
		unique case (kind)
			PH_FILL: begin
				if (roll < 75) return dht_pkg::MODE_INSERT;
				if (roll < 90) return dht_pkg::MODE_SEARCH;
				return dht_pkg::MODE_DELETE;
			end
			PH_DRAIN: begin
				if (roll < 60) return dht_pkg::MODE_DELETE;
				if (roll < 85) return dht_pkg::MODE_SEARCH;
				return dht_pkg::MODE_INSERT;
			end
			default: begin
				if (roll < 5) return MODE_UNUSED;
				if (roll < 38) return dht_pkg::MODE_INSERT;
				if (roll < 70) return dht_pkg::MODE_SEARCH;
				return dht_pkg::MODE_DELETE;
			end
		endcase
	endfunction

	initial begin
		phase_t kind;
		int len;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send_cmd(dht_pkg::MODE_INSERT, KEY_MAX);
		send_cmd(dht_pkg::MODE_SEARCH, KEY_MAX);
		send_cmd(dht_pkg::MODE_INSERT, 31'd1);
		// key 6 has a zero stride, stepped as 1
		send_cmd(dht_pkg::MODE_INSERT, 31'd6);
		send_cmd(dht_pkg::MODE_INSERT, 31'd6);
		send_cmd(dht_pkg::MODE_SEARCH, 31'd6);
		send_cmd(dht_pkg::MODE_DELETE, 31'd6);
		// home slot now empty, so the second copy is out of reach
		send_cmd(dht_pkg::MODE_SEARCH, 31'd6);
		send_cmd(dht_pkg::MODE_DELETE, 31'd6);
		send_cmd(dht_pkg::MODE_INSERT, 31'd22);
		send_cmd(dht_pkg::MODE_SEARCH, 31'd38);
		send_cmd(dht_pkg::MODE_INSERT, 31'd0);
		send_cmd(dht_pkg::MODE_SEARCH, 31'd0);
		send_cmd(dht_pkg::MODE_DELETE, 31'd0);
		send_cmd(MODE_UNUSED, 31'd1);
		send_cmd(MODE_UNUSED, 31'd0);
		send_cmd(dht_pkg::MODE_DELETE, KEY_MAX);
		send_cmd(dht_pkg::MODE_DELETE, 31'd1);
		send_cmd(dht_pkg::MODE_INSERT, 31'h4000_0000);
		send_cmd(dht_pkg::MODE_INSERT, 31'h5555_5555);
		send_cmd(dht_pkg::MODE_SEARCH, 31'h2AAA_AAAA);
		send_cmd(dht_pkg::MODE_SEARCH, 31'h5555_5555);
		drain_owed();

		// phases of mostly inserts push the table to full, drains empty it again
		while (sent < N_ITEMS) begin
			kind = phase_t'($urandom_range(0, 2));
			len = $urandom_range(20, 60);
			for (int k = 0; k < len && sent < N_ITEMS; k++)
				send_cmd(pick_mode(kind), pick_key());
			if ($urandom_range(0, 3) == 0) drain_owed();
		end

		drain_owed();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("double_hash_table: match");
		end else begin
			$display("double_hash_table: mismatch");
		end
		$finish;
	end

endmodule
